>>> sv/hexp_pkg.sv
// Shared types, codes and constants for the Intel HEX record parser.
`default_nettype none

package hexp_pkg;

   localparam int MAX_DATA_DEF   = 32;
   localparam int IMAGE_SIZE_DEF = 4096;
   localparam int QUEUE_DEPTH    = 2;
   localparam int INDEX_W        = 13;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_LF      = 8'h0a;
   localparam logic [7:0] CH_CR      = 8'h0d;
   localparam logic [7:0] CH_COLON   = 8'h3a;
   localparam logic [7:0] CH_DIG0    = 8'h30;
   localparam logic [7:0] CH_DIG9    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;

   localparam logic [7:0] REC_DATA      = 8'h00;
   localparam logic [7:0] REC_EOF       = 8'h01;
   localparam logic [7:0] REC_EXT_LIN   = 8'h04;
   localparam logic [7:0] REC_START_LIN = 8'h05;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_COMMIT = 2'd1,
      KIND_STOP   = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_CHECKSUM  = 3'd1,
      ST_BAD_DIGIT = 3'd2,
      ST_TOO_LONG  = 3'd3,
      ST_ADDR_STOP = 3'd4,
      ST_OVERFLOW  = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_FIELDS  = 2'd1,
      PH_WAIT_CR = 2'd2,
      PH_SAW_CR  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      BE_IDLE  = 2'd0,
      BE_DATA  = 2'd1,
      BE_FINAL = 2'd2
   } be_state_type;

   // One queued command: a stop, or a committed record with its byte burst.
   typedef struct packed {
      kind_type    op;
      status_type  status;
      logic [7:0]  rtype;
      logic [7:0]  nbytes;
      logic        bank;
      logic [15:0] load_offset;
      logic [31:0] upper;
      logic [31:0] app;
      logic        complete;
      logic [15:0] chars_old;
      logic [15:0] chars_new;
   } hexp_cmd_type;

   typedef struct packed {
      logic free;
      logic bank;
   } hexp_bank_free_type;

endpackage

`default_nettype wire

>>> sv/hexp_req_if.sv
// Character input channel.
`default_nettype none

interface hexp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       session_start;

   modport source (output valid, output char_in, output session_start, input ready);
   modport sink   (input valid, input char_in, input session_start, output ready);
endinterface

`default_nettype wire

>>> sv/hexp_rsp_if.sv
// Result channel.
`default_nettype none

interface hexp_rsp_if;
   import hexp_pkg::*;

   logic               valid;
   logic               ready;
   logic [1:0]         kind;
   logic [2:0]         status;
   logic [7:0]         record_type;
   logic [7:0]         data_byte;
   logic [INDEX_W-1:0] byte_index;
   logic [15:0]        load_offset;
   logic [31:0]        upper_address;
   logic [31:0]        app_address;
   logic               complete;
   logic [15:0]        chars_used;
   logic               last;

   modport source (output valid, output kind, output status, output record_type,
                   output data_byte, output byte_index, output load_offset,
                   output upper_address, output app_address, output complete,
                   output chars_used, output last, input ready);
   modport sink   (input valid, input kind, input status, input record_type,
                   input data_byte, input byte_index, input load_offset,
                   input upper_address, input app_address, input complete,
                   input chars_used, input last, output ready);
endinterface

`default_nettype wire

>>> sv/intel_hex_record_parser.sv
// Top level of the Intel HEX record parser.
`default_nettype none

// Takes one text character per transaction on req_chan and returns result
// transactions on rsp_chan. The front end accepts a character every cycle while
// the command queue has room and the byte buffer bank it fills is free; a
// character that ends a record or stops the session queues one command. The
// back end takes a command from the queue when idle, then gives one result per
// cycle while the result channel is not stalled: one per data byte, then the
// commit or stop result, before it takes the next command. Record bytes sit in
// two banks of MAX_DATA entries, so a record can be parsed while the previous
// one drains; the front end waits only when both banks are still to be drained
// or the queue is full. Reset is synchronous; there is no clearing pass.
module intel_hex_record_parser #(
   parameter int MAX_DATA   = hexp_pkg::MAX_DATA_DEF,
   parameter int IMAGE_SIZE = hexp_pkg::IMAGE_SIZE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   hexp_req_if.sink   req_chan,
   hexp_rsp_if.source rsp_chan
);
   import hexp_pkg::*;

   localparam int ILW = $clog2(IMAGE_SIZE + 1);
   localparam int KW  = $clog2(MAX_DATA > 1 ? MAX_DATA : 2);
   localparam int CMW = $bits(hexp_cmd_type);
   localparam int QW  = CMW + ILW;

   logic               push, pop, fifo_empty, fifo_full;
   hexp_cmd_type       push_cmd, head_cmd;
   logic [ILW-1:0]     push_base, head_base;
   logic [QW-1:0]      push_word, head_word;
   logic               wr_en;
   logic [KW:0]        wr_addr;
   logic [7:0]         wr_data;
   hexp_bank_free_type bank_free;

   assign push_word              = {push_cmd, push_base};
   assign {head_cmd, head_base}  = head_word;

   hexp_front #(
      .MAX_DATA   (MAX_DATA),
      .IMAGE_SIZE (IMAGE_SIZE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .fifo_full (fifo_full),
      .bank_free (bank_free),
      .push      (push),
      .push_cmd  (push_cmd),
      .push_base (push_base),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data)
   );

   hexp_cmd_fifo #(
      .W     (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_word),
      .pop       (pop),
      .head_data (head_word),
      .empty     (fifo_empty),
      .full      (fifo_full)
   );

   hexp_back #(
      .MAX_DATA   (MAX_DATA),
      .IMAGE_SIZE (IMAGE_SIZE)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_empty (fifo_empty),
      .head_cmd   (head_cmd),
      .head_base  (head_base),
      .pop        (pop),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .bank_free  (bank_free),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

>>> sv/hexp_cmd_fifo.sv
// Short command queue between the parser front end and the result back end.
`default_nettype none

module hexp_cmd_fifo #(
   parameter int W     = 8,
   parameter int DEPTH = hexp_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   input  logic         pop,
   output logic [W-1:0] head_data,
   output logic         empty,
   output logic         full
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [W-1:0]  store_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CW'(DEPTH));
   assign head_data = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> sv/hexp_front.sv
// Front end: character parser, record checks and commit decisions.
`default_nettype none

module hexp_front #(
   parameter int MAX_DATA   = hexp_pkg::MAX_DATA_DEF,
   parameter int IMAGE_SIZE = hexp_pkg::IMAGE_SIZE_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   hexp_req_if.sink                               req_chan,
   input  logic                                   fifo_full,
   input  hexp_pkg::hexp_bank_free_type           bank_free,
   output logic                                   push,
   output hexp_pkg::hexp_cmd_type                 push_cmd,
   output logic [$clog2(IMAGE_SIZE + 1)-1:0]      push_base,
   output logic                                   wr_en,
   output logic [$clog2(MAX_DATA > 1 ? MAX_DATA : 2):0] wr_addr,
   output logic [7:0]                             wr_data
);
   import hexp_pkg::*;

   localparam int ILW = $clog2(IMAGE_SIZE + 1);
   localparam int KW  = $clog2(MAX_DATA > 1 ? MAX_DATA : 2);
   localparam int SW  = ((ILW > 8) ? ILW : 8) + 1;

   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = '0;
      if (c >= CH_DIG0 && c <= CH_DIG9) begin
         r = {1'b1, 4'(c - CH_DIG0)};
      end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
         r = {1'b1, 4'(c - CH_LOWER_A + 8'd10)};
      end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
         r = {1'b1, 4'(c - CH_UPPER_A + 8'd10)};
      end
      return r;
   endfunction

   phase_type   phase_ff, phase_in;
   logic [8:0]  nib_ff, nib_in;
   logic [3:0]  pend_ff, pend_in;
   logic [7:0]  len_ff, len_in;
   logic [15:0] addr_ff, addr_in;
   logic [7:0]  rkind_ff, rkind_in;
   logic [7:0]  sum_ff, sum_in;
   logic [31:0] fold_ff, fold_in;
   logic [ILW-1:0] img_ff, img_in;
   logic [15:0] first_off_ff, first_off_in;
   logic        taken_ff, taken_in;
   logic [31:0] base_ff, base_in;
   logic        chg_ff, chg_in;
   logic [31:0] entry_ff, entry_in;
   logic        done_ff, done_in;
   logic [15:0] cc_ff, cc_in;
   logic [15:0] rsc_ff, rsc_in;
   logic        stopped_ff, stopped_in;
   logic        wr_bank_ff, wr_bank_in;
   logic [1:0]  busy_ff, busy_in;

   logic        accept, ss, live, step, is_nul, colon, in_fields, bad;
   logic        nib_ev, byte_ev, past_hdr, data_ev, ck_ev, ck_bad, too_long;
   logic        wait_cr, saw_cr, lf, is_data, ovf, lin, lin_stop, commit_ok;
   logic        stop, fill, hv;
   logic [3:0]  hd;
   logic [7:0]  ch, bidx, byte_val, sum_new, kidx;
   logic [8:0]  nib, data_end;
   logic [7:0]  sum;
   logic [ILW-1:0] img;
   logic [15:0] rsc, cc, cc_next;
   logic        taken;
   logic [31:0] new_base;
   status_type  stop_status;

   assign accept         = req_chan.valid && req_chan.ready;
   assign req_chan.ready = !fifo_full && !busy_ff[wr_bank_ff];

   // Event decode; session start clears parse and count state before using the character.
   always_comb begin
      ss        = accept && req_chan.session_start;
      live      = accept && (!stopped_ff || req_chan.session_start);
      ch        = req_chan.char_in;
      {hv, hd}  = hex_decode(ch);
      nib       = ss ? '0 : nib_ff;
      sum       = ss ? '0 : sum_ff;
      img       = ss ? '0 : img_ff;
      rsc       = ss ? '0 : rsc_ff;
      cc        = ss ? '0 : cc_ff;
      taken     = ss ? 1'b0 : taken_ff;
      is_nul    = live && (ch == CH_NUL);
      step      = live && (ch != CH_NUL);
      colon     = step && (ss || phase_ff == PH_HUNT) && (ch == CH_COLON);
      in_fields = step && !ss && (phase_ff == PH_FIELDS);
      wait_cr   = step && !ss && (phase_ff == PH_WAIT_CR);
      saw_cr    = step && !ss && (phase_ff == PH_SAW_CR);
      bad       = in_fields && !hv;
      nib_ev    = in_fields && hv;
      byte_ev   = nib_ev && nib[0];
      bidx      = nib[8:1];
      byte_val  = {pend_ff, hd};
      sum_new   = sum + byte_val;
      kidx      = bidx - 8'd4;
      data_end  = 9'd4 + {1'b0, len_ff};
      too_long  = byte_ev && (bidx == 8'd0) && ({1'b0, byte_val} > 9'(MAX_DATA));
      past_hdr  = byte_ev && (bidx >= 8'd4);
      data_ev   = past_hdr && ({1'b0, bidx} < data_end);
      ck_ev     = past_hdr && !({1'b0, bidx} < data_end);
      ck_bad    = ck_ev && (sum_new != 8'd0);
      lf        = saw_cr && (ch == CH_LF);
      cc_next   = (step && cc != 16'hffff) ? cc + 16'd1 : cc;
      new_base  = {fold_ff[15:0], 16'h0000};
      is_data   = (rkind_ff == REC_DATA);
      ovf       = lf && is_data && ((SW'(img) + SW'(len_ff)) > SW'(IMAGE_SIZE));
      lin       = lf && (rkind_ff == REC_EXT_LIN);
      lin_stop  = lin && (base_ff != '0) && (base_ff != new_base) && !chg_ff;
      commit_ok = lf && !ovf && !lin_stop;
      stop      = is_nul || bad || too_long || ck_bad || ovf || lin_stop;
      fill      = commit_ok && is_data && (len_ff != 8'd0);
      priority if (bad) begin
         stop_status = ST_BAD_DIGIT;
      end else if (too_long) begin
         stop_status = ST_TOO_LONG;
      end else if (ck_bad) begin
         stop_status = ST_CHECKSUM;
      end else if (ovf) begin
         stop_status = ST_OVERFLOW;
      end else if (lin_stop) begin
         stop_status = ST_ADDR_STOP;
      end else begin
         stop_status = ST_OK;
      end
   end

   // Parse phase
   always_comb begin
      phase_in = ss ? PH_HUNT : phase_ff;
      if (live) begin
         priority if (stop || lf) begin
            phase_in = PH_HUNT;
         end else if (colon) begin
            phase_in = PH_FIELDS;
         end else if (ck_ev) begin
            phase_in = PH_WAIT_CR;
         end else if (wait_cr && ch == CH_CR) begin
            phase_in = PH_SAW_CR;
         end else if (saw_cr && ch != CH_CR) begin
            phase_in = PH_WAIT_CR;
         end else begin
            phase_in = phase_in;
         end
      end
   end

   // Record fields and session state
   always_comb begin
      nib_in       = colon ? '0 : (nib_ev ? nib + 9'd1 : nib);
      pend_in      = (nib_ev && !nib[0]) ? hd : pend_ff;
      len_in       = len_ff;
      addr_in      = addr_ff;
      rkind_in     = rkind_ff;
      sum_in       = colon ? '0 : (byte_ev ? sum_new : sum);
      fold_in      = colon ? '0 : (data_ev ? {fold_ff[23:0], byte_val} : fold_ff);
      if (colon) begin
         len_in   = '0;
         addr_in  = '0;
         rkind_in = '0;
      end else if (byte_ev) begin
         if (bidx == 8'd0) len_in   = byte_val;
         if (bidx == 8'd1) addr_in  = {byte_val, 8'h00};
         if (bidx == 8'd2) addr_in  = addr_ff | {8'h00, byte_val};
         if (bidx == 8'd3) rkind_in = byte_val;
      end
      img_in       = (commit_ok && is_data) ? ILW'(img + ILW'(len_ff)) : img;
      first_off_in = (commit_ok && is_data && !taken) ? addr_ff : first_off_ff;
      taken_in     = taken || (commit_ok && is_data);
      base_in      = base_ff;
      chg_in       = chg_ff;
      if (commit_ok && lin) begin
         if (base_ff == '0) begin
            base_in = new_base;
         end else if (base_ff != new_base) begin
            base_in = new_base;
            chg_in  = 1'b0;
         end
      end else if (lin_stop) begin
         chg_in = 1'b1;
      end
      entry_in     = (commit_ok && rkind_ff == REC_START_LIN) ? fold_ff : entry_ff;
      done_in      = done_ff || (commit_ok && rkind_ff == REC_EOF);
      cc_in        = cc_next;
      rsc_in       = commit_ok ? cc_next : rsc;
      stopped_in   = (stopped_ff && !ss) || stop;
      wr_bank_in   = wr_bank_ff ^ fill;
      busy_in      = busy_ff;
      if (bank_free.free) busy_in[bank_free.bank] = 1'b0;
      if (fill) busy_in[wr_bank_ff] = 1'b1;
   end

   // Queue and byte buffer outputs
   always_comb begin
      push                 = stop || commit_ok;
      push_cmd.op          = stop ? KIND_STOP : KIND_COMMIT;
      push_cmd.status      = stop_status;
      push_cmd.rtype       = rkind_ff;
      push_cmd.nbytes      = fill ? len_ff : 8'd0;
      push_cmd.bank        = wr_bank_ff;
      push_cmd.load_offset = first_off_in;
      push_cmd.upper       = base_in;
      push_cmd.app         = entry_in;
      push_cmd.complete    = done_in;
      push_cmd.chars_old   = rsc;
      push_cmd.chars_new   = rsc_in;
      push_base            = img;
      wr_en                = data_ev && ({1'b0, kidx} < 9'(MAX_DATA));
      wr_addr              = {wr_bank_ff, kidx[KW-1:0]};
      wr_data              = byte_val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         nib_ff       <= '0;
         pend_ff      <= '0;
         len_ff       <= '0;
         addr_ff      <= '0;
         rkind_ff     <= '0;
         sum_ff       <= '0;
         fold_ff      <= '0;
         img_ff       <= '0;
         first_off_ff <= '0;
         taken_ff     <= 1'b0;
         base_ff      <= '0;
         chg_ff       <= 1'b0;
         entry_ff     <= '0;
         done_ff      <= 1'b0;
         cc_ff        <= '0;
         rsc_ff       <= '0;
         stopped_ff   <= 1'b0;
         wr_bank_ff   <= 1'b0;
         busy_ff      <= '0;
      end else begin
         phase_ff     <= phase_in;
         nib_ff       <= nib_in;
         pend_ff      <= pend_in;
         len_ff       <= len_in;
         addr_ff      <= addr_in;
         rkind_ff     <= rkind_in;
         sum_ff       <= sum_in;
         fold_ff      <= fold_in;
         img_ff       <= img_in;
         first_off_ff <= first_off_in;
         taken_ff     <= taken_in;
         base_ff      <= base_in;
         chg_ff       <= chg_in;
         entry_ff     <= entry_in;
         done_ff      <= done_in;
         cc_ff        <= cc_in;
         rsc_ff       <= rsc_in;
         stopped_ff   <= stopped_in;
         wr_bank_ff   <= wr_bank_in;
         busy_ff      <= busy_in;
      end
   end

`ifndef SYNTH
   a_write_free_bank: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !busy_ff[wr_bank_ff])
      else $error("byte buffer write into a bank still being drained");
   a_free_busy_bank: assert property (@(posedge clock) disable iff (reset)
      bank_free.free |-> busy_ff[bank_free.bank])
      else $error("bank released that was not in use");
   a_stopped_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && stopped_ff && !req_chan.session_start) |-> !push)
      else $error("command queued from a stopped session");
`endif

endmodule

`default_nettype wire

>>> sv/hexp_back.sv
// Back end: drains commands into results, one per cycle unless stalled.
`default_nettype none

module hexp_back #(
   parameter int MAX_DATA   = hexp_pkg::MAX_DATA_DEF,
   parameter int IMAGE_SIZE = hexp_pkg::IMAGE_SIZE_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   fifo_empty,
   input  hexp_pkg::hexp_cmd_type                 head_cmd,
   input  logic [$clog2(IMAGE_SIZE + 1)-1:0]      head_base,
   output logic                                   pop,
   input  logic                                   wr_en,
   input  logic [$clog2(MAX_DATA > 1 ? MAX_DATA : 2):0] wr_addr,
   input  logic [7:0]                             wr_data,
   output hexp_pkg::hexp_bank_free_type           bank_free,
   hexp_rsp_if.source                             rsp_chan
);
   import hexp_pkg::*;

   localparam int ILW = $clog2(IMAGE_SIZE + 1);
   localparam int KW  = $clog2(MAX_DATA > 1 ? MAX_DATA : 2);

   logic [7:0] mem [2 ** (KW + 1)];

   be_state_type   st_ff, st_in;
   hexp_cmd_type   cur_ff, cur_in;
   logic [ILW-1:0] cur_base_ff, cur_base_in;
   logic [7:0]     j_ff, j_in;

   logic               out_valid_ff;
   kind_type           out_kind_ff;
   status_type         out_status_ff;
   logic [7:0]         out_rtype_ff;
   logic [INDEX_W-1:0] out_index_ff;
   logic [15:0]        out_offset_ff;
   logic [31:0]        out_upper_ff;
   logic [31:0]        out_app_ff;
   logic               out_complete_ff;
   logic [15:0]        out_chars_ff;
   logic               out_last_ff;
   logic [7:0]         rd_data_ff;

   logic           adv, emit, emit_data, last_byte;
   logic [ILW-1:0] idx;

   assign adv       = !out_valid_ff || rsp_chan.ready;
   assign last_byte = (j_ff == cur_ff.nbytes - 8'd1);
   assign idx       = cur_base_ff + ILW'(emit_data ? j_ff : cur_ff.nbytes);

   // Sequencer next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         BE_IDLE: begin
            if (!fifo_empty) begin
               st_in = (head_cmd.op == KIND_COMMIT && head_cmd.nbytes != 8'd0) ?
                       BE_DATA : BE_FINAL;
            end
         end
         BE_DATA: begin
            if (adv && last_byte) st_in = BE_FINAL;
         end
         BE_FINAL: begin
            if (adv) st_in = BE_IDLE;
         end
         default: st_in = BE_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      pop            = (st_ff == BE_IDLE) && !fifo_empty;
      emit_data      = (st_ff == BE_DATA) && adv;
      emit           = emit_data || ((st_ff == BE_FINAL) && adv);
      bank_free.free = emit_data && last_byte;
      bank_free.bank = cur_ff.bank;
   end

   always_comb begin
      cur_in      = pop ? head_cmd : cur_ff;
      cur_base_in = pop ? head_base : cur_base_ff;
      j_in        = pop ? 8'd0 : (emit_data ? j_ff + 8'd1 : j_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= BE_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      cur_base_ff <= cur_base_in;
      j_ff        <= j_in;
      if (emit) begin
         out_kind_ff     <= emit_data ? KIND_DATA : cur_ff.op;
         out_status_ff   <= emit_data ? ST_OK : cur_ff.status;
         out_rtype_ff    <= cur_ff.rtype;
         out_index_ff    <= INDEX_W'(idx);
         out_offset_ff   <= cur_ff.load_offset;
         out_upper_ff    <= cur_ff.upper;
         out_app_ff      <= cur_ff.app;
         out_complete_ff <= cur_ff.complete;
         // data bytes go out before the record start count moves
         out_chars_ff    <= emit_data ? cur_ff.chars_old : cur_ff.chars_new;
         out_last_ff     <= !emit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (emit_data) begin
         rd_data_ff <= mem[{cur_ff.bank, j_ff[KW-1:0]}];
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.kind          = out_kind_ff;
   assign rsp_chan.status        = out_status_ff;
   assign rsp_chan.record_type   = out_rtype_ff;
   assign rsp_chan.data_byte     = (out_kind_ff == KIND_DATA) ? rd_data_ff : 8'h00;
   assign rsp_chan.byte_index    = out_index_ff;
   assign rsp_chan.load_offset   = out_offset_ff;
   assign rsp_chan.upper_address = out_upper_ff;
   assign rsp_chan.app_address   = out_app_ff;
   assign rsp_chan.complete      = out_complete_ff;
   assign rsp_chan.chars_used    = out_chars_ff;
   assign rsp_chan.last          = out_last_ff;

`ifndef SYNTH
   a_burst_in_range: assert property (@(posedge clock) disable iff (reset)
      (st_ff == BE_DATA) |-> (j_ff < cur_ff.nbytes))
      else $error("byte burst ran past the record length");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (wr_en && st_ff == BE_DATA) |-> (wr_addr[KW] != cur_ff.bank))
      else $error("front end wrote the bank being drained");
   a_data_not_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_kind_ff == KIND_DATA) |-> !out_last_ff)
      else $error("data byte transaction marked last");
`endif

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// Self-checking bench for the Intel HEX record parser, with a built-in predictor.
`default_nettype none

module tb_top;
   import hexp_pkg::*;

   // unhandled record types, committed without effect
   localparam logic [7:0] REC_START_SEG = 8'h03;
   localparam logic [7:0] REC_TYPE_MAX  = 8'hff;

   typedef struct packed {
      kind_type           kind;
      status_type         status;
      logic [7:0]         rtype;
      logic [7:0]         data;
      logic [INDEX_W-1:0] index;
      logic [15:0]        offset;
      logic [31:0]        upper;
      logic [31:0]        app;
      logic               done;
      logic [15:0]        used;
      logic               last;
   } hex_result_type;

   logic clock;
   logic reset;
   bit   steady;

   hexp_req_if req_chan ();
   hexp_rsp_if rsp_chan ();

   intel_hex_record_parser uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   hex_result_type due_results [$];
   logic [7:0]     line_buf [$];
   logic [7:0]     payload [0:MAX_DATA_DEF-1];

   int sent_chars, live_chars, checked_results, fault_count;
   int n_data, n_commit, n_stop, step_count;

   // parser state as seen by the predictor
   phase_type   ps_phase;
   int          nib_cnt;
   logic [3:0]  nib_hi;
   int          rec_len;
   logic [15:0] rec_addr;
   logic [7:0]  rec_type;
   logic [7:0]  rec_sum;
   logic [7:0]  rec_data [0:MAX_DATA_DEF-1];
   int          img_len;
   logic [15:0] first_off;
   bit          off_taken;
   logic [31:0] lin_base;
   bit          base_change_held;
   logic [31:0] start_addr;
   bit          eof_seen;
   int          char_cnt;
   int          rec_start_cnt;
   bit          sess_stopped;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int hex_nibble(logic [7:0] c);
      if (c >= CH_DIG0 && c <= CH_DIG9) return int'(c - CH_DIG0);
      if (c >= CH_LOWER_A && c <= CH_LOWER_F) return int'(c - CH_LOWER_A) + 10;
      if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c - CH_UPPER_A) + 10;
      return -1;
   endfunction

   function automatic void clear_parser();
      ps_phase         = PH_HUNT;
      nib_cnt          = 0;
      nib_hi           = '0;
      rec_len          = 0;
      rec_addr         = '0;
      rec_type         = '0;
      rec_sum          = '0;
      img_len          = 0;
      first_off        = '0;
      off_taken        = 1'b0;
      lin_base         = '0;
      base_change_held = 1'b0;
      start_addr       = '0;
      eof_seen         = 1'b0;
      char_cnt         = 0;
      rec_start_cnt    = 0;
      sess_stopped     = 1'b0;
   endfunction

   function automatic void push_result(kind_type k, status_type s, logic [7:0] d, int idx);
      hex_result_type r;
      r.kind   = k;
      r.status = s;
      r.rtype  = rec_type;
      r.data   = d;
      r.index  = INDEX_W'(idx);
      r.offset = first_off;
      r.upper  = lin_base;
      r.app    = start_addr;
      r.done   = eof_seen;
      r.used   = 16'(rec_start_cnt);
      r.last   = 1'b0;
      due_results.push_back(r);
      step_count++;
   endfunction

   function automatic void stop_session(status_type s);
      push_result(KIND_STOP, s, 8'h00, img_len);
      sess_stopped = 1'b1;
      ps_phase     = PH_HUNT;
   endfunction

   function automatic logic [31:0] folded_payload();
      logic [31:0] v;
      v = '0;
      for (int j = 0; j < rec_len && j < MAX_DATA_DEF; j++) v = (v << 8) + rec_data[j];
      return v;
   endfunction

   function automatic void commit_record();
      logic [31:0] base;
      ps_phase = PH_HUNT;
      if (rec_type == REC_DATA) begin
         if (img_len + rec_len > IMAGE_SIZE_DEF) begin
            stop_session(ST_OVERFLOW);
            return;
         end
         if (!off_taken) begin
            first_off = rec_addr;
            off_taken = 1'b1;
         end
         for (int j = 0; j < rec_len && j < MAX_DATA_DEF; j++)
            push_result(KIND_DATA, ST_OK, rec_data[j], img_len + j);
         img_len += rec_len;
      end else if (rec_type == REC_EOF) begin
         eof_seen = 1'b1;
      end else if (rec_type == REC_EXT_LIN) begin
         base = folded_payload() << 16;
         if (lin_base == '0) begin
            lin_base = base;
         end else if (lin_base != base) begin
            // first change stops the session, the retry adopts it
            if (!base_change_held) begin
               base_change_held = 1'b1;
               stop_session(ST_ADDR_STOP);
               return;
            end
            lin_base         = base;
            base_change_held = 1'b0;
         end
      end else if (rec_type == REC_START_LIN) begin
         start_addr = folded_payload();
      end
      rec_start_cnt = char_cnt;
      push_result(KIND_COMMIT, ST_OK, 8'h00, img_len);
   endfunction

   function automatic void take_byte(logic [7:0] v, int b);
      rec_sum += v;
      if (b == 0) begin
         rec_len = int'(v);
         if (rec_len > MAX_DATA_DEF) stop_session(ST_TOO_LONG);
      end else if (b == 1) begin
         rec_addr = {v, 8'h00};
      end else if (b == 2) begin
         rec_addr = rec_addr | 16'(v);
      end else if (b == 3) begin
         rec_type = v;
      end else if (b < 4 + rec_len) begin
         if (b - 4 < MAX_DATA_DEF) rec_data[b-4] = v;
      end else if (rec_sum != 8'h00) begin
         stop_session(ST_CHECKSUM);
      end else begin
         ps_phase = PH_WAIT_CR;
      end
   endfunction

   function automatic void hex_parse_step(logic [7:0] c, logic ss);
      int             d;
      int             b;
      hex_result_type tail;
      step_count = 0;
      if (ss) begin
         img_len       = 0;
         off_taken     = 1'b0;
         char_cnt      = 0;
         rec_start_cnt = 0;
         sess_stopped  = 1'b0;
         ps_phase      = PH_HUNT;
         nib_cnt       = 0;
         rec_sum       = '0;
      end
      if (sess_stopped) return;
      if (c == CH_NUL) begin
         stop_session(ST_OK);
      end else begin
         if (char_cnt < 16'hffff) char_cnt++;
         case (ps_phase)
            PH_HUNT: begin
               if (c == CH_COLON) begin
                  ps_phase = PH_FIELDS;
                  nib_cnt  = 0;
                  rec_sum  = '0;
                  rec_len  = 0;
                  rec_addr = '0;
                  rec_type = '0;
               end
            end
            PH_FIELDS: begin
               d = hex_nibble(c);
               if (d < 0) begin
                  stop_session(ST_BAD_DIGIT);
               end else if (nib_cnt % 2 == 0) begin
                  nib_hi = d[3:0];
                  nib_cnt++;
               end else begin
                  b = nib_cnt / 2;
                  nib_cnt++;
                  take_byte({nib_hi, d[3:0]}, b);
               end
            end
            PH_WAIT_CR: begin
               if (c == CH_CR) ps_phase = PH_SAW_CR;
            end
            default: begin
               if (c == CH_LF) commit_record();
               else if (c != CH_CR) ps_phase = PH_WAIT_CR;
            end
         endcase
      end
      if (step_count > 0) begin
         tail = due_results.pop_back();
         tail.last = 1'b1;
         due_results.push_back(tail);
      end
   endfunction

   // ------------------------------------------------------------ text builders

   function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
      if (n < 4'd10) return CH_DIG0 + 8'(n);
      return (lower ? CH_LOWER_A : CH_UPPER_A) + 8'(n) - 8'd10;
   endfunction

   function automatic void put_hex(logic [7:0] v, bit lower);
      line_buf.push_back(hex_char(v[7:4], lower));
      line_buf.push_back(hex_char(v[3:0], lower));
   endfunction

   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == CH_COLON);
      return c;
   endfunction

   function automatic logic [7:0] non_hex_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (hex_nibble(c) >= 0);
      return c;
   endfunction

   function automatic void fill_payload();
      for (int j = 0; j < MAX_DATA_DEF; j++) payload[j] = 8'($urandom);
   endfunction

   function automatic void put_record(int len, logic [15:0] addr, logic [7:0] rtype,
                                      bit bad_sum, bit lower);
      logic [7:0] sum;
      sum = 8'(len) + addr[15:8] + addr[7:0] + rtype;
      line_buf.push_back(CH_COLON);
      put_hex(8'(len), lower);
      put_hex(addr[15:8], lower);
      put_hex(addr[7:0], lower);
      put_hex(rtype, lower);
      for (int j = 0; j < len && j < MAX_DATA_DEF; j++) begin
         sum += payload[j];
         put_hex(payload[j], lower);
      end
      sum = -sum;
      if (bad_sum) sum += 8'($urandom_range(1, 255));
      put_hex(sum, lower);
      line_buf.push_back(CH_CR);
      line_buf.push_back(CH_LF);
   endfunction

   // strip the line ending so extra text can go in before it
   function automatic void open_line_end();
      void'(line_buf.pop_back());
      void'(line_buf.pop_back());
   endfunction

   // ------------------------------------------------------------------ driving

   task automatic send_char(logic [7:0] c, logic ss);
      @(negedge clock);
      while (!steady && $urandom_range(99) < 38) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.char_in       <= c;
      req_chan.session_start <= ss;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (ss || !sess_stopped) live_chars++;
      hex_parse_step(c, ss);
      sent_chars++;
   endtask

   task automatic send_line(logic ss);
      for (int i = 0; i < line_buf.size(); i++) send_char(line_buf[i], (i == 0) ? ss : 1'b0);
      line_buf.delete();
   endtask

   task automatic pause_until_drained();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (due_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= steady || ($urandom_range(99) >= 38);
      end
   end

   // ----------------------------------------------------------------- checking

   task automatic report_fault(string msg);
      fault_count++;
      if (fault_count <= 100) $display("MISMATCH: %s", msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_fault($sformatf("result %0d: %s is 'h%0h, expected 'h%0h",
                                checked_results, name, got, want));
   endtask

   task automatic check_result();
      hex_result_type want;
      checked_results++;
      if (due_results.size() == 0) begin
         report_fault($sformatf("result %0d (kind %0d) arrived with nothing expected",
                                checked_results, rsp_chan.kind));
         return;
      end
      want = due_results.pop_front();
      case (want.kind)
         KIND_DATA:   n_data++;
         KIND_COMMIT: n_commit++;
         default:     n_stop++;
      endcase
      check_field("kind", rsp_chan.kind, want.kind);
      check_field("status", rsp_chan.status, want.status);
      check_field("record_type", rsp_chan.record_type, want.rtype);
      check_field("data_byte", rsp_chan.data_byte, want.data);
      check_field("byte_index", rsp_chan.byte_index, want.index);
      check_field("load_offset", rsp_chan.load_offset, want.offset);
      check_field("upper_address", rsp_chan.upper_address, want.upper);
      check_field("app_address", rsp_chan.app_address, want.app);
      check_field("complete", rsp_chan.complete, want.done);
      check_field("chars_used", rsp_chan.chars_used, want.used);
      check_field("last", rsp_chan.last, want.last);
   endtask

   initial begin
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)
            check_result();
      end
   end

   // -------------------------------------------------------------------- tests

   task automatic test_record_types();
      fill_payload();
      payload[0] = 8'h00;
      payload[1] = 8'hff;
      payload[2] = 8'h5a;
      payload[3] = 8'ha5;
      put_record(4, 16'hffff, REC_DATA, 1'b0, 1'b0);
      send_line(1'b1);
      put_record(0, 16'h0000, REC_DATA, 1'b0, 1'b1);
      send_line(1'b0);
      fill_payload();
      put_record(MAX_DATA_DEF, 16'(16'h1234), REC_DATA, 1'b0, 1'b1);
      send_line(1'b0);
      for (int j = 0; j < 4; j++) payload[j] = 8'hff;
      put_record(4, 16'h0000, REC_START_LIN, 1'b0, 1'b0);
      send_line(1'b0);
      fill_payload();
      put_record(4, 16'($urandom), REC_START_LIN, 1'b0, 1'b1);
      send_line(1'b0);
      put_record(2, 16'($urandom), REC_START_SEG, 1'b0, 1'b0);
      send_line(1'b0);
      put_record(1, 16'($urandom), REC_TYPE_MAX, 1'b0, 1'b1);
      send_line(1'b0);
      put_record(0, 16'h0000, REC_EOF, 1'b0, 1'b0);
      send_line(1'b0);
   endtask

   task automatic test_upper_address();
      pause_until_drained();
      payload[0] = 8'h00;
      payload[1] = 8'h01;
      put_record(2, 16'h0000, REC_EXT_LIN, 1'b0, 1'b0);
      send_line(1'b1);
      put_record(2, 16'h0000, REC_EXT_LIN, 1'b0, 1'b0);
      send_line(1'b0);
      payload[0] = 8'hff;
      payload[1] = 8'hff;
      put_record(2, 16'h0000, REC_EXT_LIN, 1'b0, 1'b0);
      send_line(1'b0);
      // session is stopped: these go nowhere
      send_char(CH_COLON, 1'b0);
      send_char(CH_NUL, 1'b0);
      put_record(2, 16'h0000, REC_EXT_LIN, 1'b0, 1'b0);
      send_line(1'b1);
      fill_payload();
      put_record(3, 16'($urandom), REC_DATA, 1'b0, 1'b0);
      send_line(1'b0);
   endtask

   task automatic test_parse_errors();
      fill_payload();
      put_record(3, 16'($urandom), REC_DATA, 1'b1, 1'b0);
      send_line(1'b1);
      put_record(3, 16'($urandom), REC_DATA, 1'b0, 1'b0);
      line_buf[4] = non_hex_char();
      send_line(1'b1);
      put_record(MAX_DATA_DEF + 1, 16'($urandom), REC_DATA, 1'b0, 1'b0);
      send_line(1'b1);
      put_record(255, 16'($urandom), REC_DATA, 1'b0, 1'b1);
      send_line(1'b1);
      put_record(5, 16'($urandom), REC_DATA, 1'b0, 1'b0);
      line_buf[9] = CH_NUL;
      send_line(1'b1);
      send_char(CH_NUL, 1'b1);
      send_char(CH_NUL, 1'b0);
      send_char(CH_COLON, 1'b0);
      // trailing text, a lone LF and a CR without LF before the real line end
      put_record(2, 16'($urandom), REC_DATA, 1'b0, 1'b0);
      open_line_end();
      line_buf.push_back(non_hex_char());
      line_buf.push_back(CH_LF);
      line_buf.push_back(CH_CR);
      line_buf.push_back(CH_DIG0);
      line_buf.push_back(CH_CR);
      line_buf.push_back(CH_CR);
      line_buf.push_back(CH_LF);
      send_line(1'b1);
   endtask

   task automatic test_image_overflow();
      for (int i = 0; i < IMAGE_SIZE_DEF / MAX_DATA_DEF; i++) begin
         fill_payload();
         put_record(MAX_DATA_DEF, 16'($urandom), REC_DATA, 1'b0, i % 2 == 1);
         send_line(i == 0);
      end
      // full image: an empty record still fits, one more byte does not
      put_record(0, 16'($urandom), REC_DATA, 1'b0, 1'b0);
      send_line(1'b0);
      fill_payload();
      put_record(1, 16'($urandom), REC_DATA, 1'b0, 1'b0);
      send_line(1'b0);
   endtask

   task automatic test_char_saturation();
      steady = 1'b1;
      send_char(junk_char(), 1'b1);
      for (int i = 0; i < 65600; i++) send_char(junk_char(), 1'b0);
      fill_payload();
      put_record(1, 16'($urandom), REC_DATA, 1'b0, 1'b0);
      send_line(1'b0);
      put_record(0, 16'h0000, REC_EOF, 1'b0, 1'b0);
      send_line(1'b0);
      steady = 1'b0;
   endtask

   task automatic random_record();
      int         r;
      int         len;
      logic [7:0] rtype;
      logic       ss;
      ss = sess_stopped ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
      fill_payload();
      r = $urandom_range(99);
      if (r < 55) begin
         rtype = REC_DATA;
         len   = ($urandom_range(9) == 0) ? $urandom_range(9, MAX_DATA_DEF) : $urandom_range(8);
      end else if (r < 63) begin
         rtype = REC_EOF;
         len   = 0;
      end else if (r < 80) begin
         // few distinct bases so changes and retries come up often
         rtype      = REC_EXT_LIN;
         len        = ($urandom_range(7) == 0) ? $urandom_range(4) : 2;
         payload[0] = 8'h00;
         payload[1] = 8'($urandom_range(3));
      end else if (r < 88) begin
         rtype = REC_START_LIN;
         len   = 4;
      end else begin
         rtype = 8'($urandom);
         len   = $urandom_range(MAX_DATA_DEF);
      end
      if ($urandom_range(24) == 0) len = $urandom_range(MAX_DATA_DEF + 1, 255);
      if ($urandom_range(4) == 0)
         repeat ($urandom_range(1, 6)) line_buf.push_back(junk_char());
      put_record(len, 16'($urandom), rtype, $urandom_range(19) == 0, $urandom_range(2) == 0);
      r = $urandom_range(99);
      if (r < 5) begin
         line_buf[$urandom_range(1, line_buf.size() - 3)] = non_hex_char();
      end else if (r < 8) begin
         line_buf[$urandom_range(line_buf.size() - 1)] = CH_NUL;
      end else if (r < 16) begin
         open_line_end();
         line_buf.push_back(junk_char());
         if ($urandom_range(1) == 1) line_buf.push_back(CH_LF);
         line_buf.push_back(CH_CR);
         line_buf.push_back(junk_char());
         line_buf.push_back(CH_CR);
         line_buf.push_back(CH_LF);
      end
      send_line(ss);
   endtask

   task automatic test_random_stream();
      int first;
      int n;
      first = live_chars;
      n     = 0;
      while (live_chars - first < 400) begin
         steady = (n >= 8 && n < 16);
         random_record();
         n++;
      end
      steady = 1'b0;
   endtask

   // --------------------------------------------------------------------- main

   initial begin
      reset                  = 1'b1;
      steady                 = 1'b0;
      req_chan.valid         = 1'b0;
      req_chan.char_in       = 8'h00;
      req_chan.session_start = 1'b0;
      clear_parser();
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_record_types();
      test_upper_address();
      test_parse_errors();
      test_image_overflow();
      test_char_saturation();
      test_random_stream();

      pause_until_drained();
      repeat (100) @(posedge clock);

      $display("Sent %0d characters (%0d parsed); checked %0d results:", sent_chars,
               live_chars, checked_results);
      $display("  %0d data bytes, %0d committed records, %0d session stops, %0d faults",
               n_data, n_commit, n_stop, fault_count);
      if (fault_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> intel_hex_record_parser.f
sv/hexp_pkg.sv
sv/hexp_req_if.sv
sv/hexp_rsp_if.sv
sv/hexp_cmd_fifo.sv
sv/hexp_front.sv
sv/hexp_back.sv
sv/intel_hex_record_parser.sv
bench/tb_top.sv
